@@ rtl/lcgsa_pkg.sv @@
package lcgsa_pkg;

  localparam int unsigned StepBits = 32;
  localparam logic [31:0] LcgMul = 32'h0003_43FD;
  localparam logic [31:0] LcgInc = 32'h0026_9EC3;

  typedef struct packed {
    logic        valid;
    logic [31:0] seed;
    logic [31:0] steps;
  } stage_t;

  // multiplier of the map that advances 2^k steps
  function automatic logic [31:0] jump_mul(int k);
    logic [31:0] m;
    m = LcgMul;
    for (int i = 0; i < k; i++) begin
      m = 32'(m * m);
    end
    return m;
  endfunction

  // increment of the map that advances 2^k steps
  function automatic logic [31:0] jump_add(int k);
    logic [31:0] m;
    logic [31:0] c;
    m = LcgMul;
    c = LcgInc;
    for (int i = 0; i < k; i++) begin
      c = 32'((m + 32'd1) * c);
      m = 32'(m * m);
    end
    return c;
  endfunction

endpackage

@@ rtl/lcgsa_stage.sv @@
module lcgsa_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [31:0]         mul_k,
  input  logic [31:0]         add_k,
  input  lcgsa_pkg::stage_t   stage_in,
  output lcgsa_pkg::stage_t   stage_out
);

  logic [31:0] prod;
  logic [31:0] seed_next;

  assign prod      = 32'(stage_in.seed * mul_k);
  assign seed_next = stage_in.steps[0] ? 32'(prod + add_k) : stage_in.seed;

  // advance by 2^k steps where this bit of the count is set
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_in.valid;
    end
    if (en) begin
      stage_out.seed  <= seed_next;
      stage_out.steps <= {1'b0, stage_in.steps[31:1]};
    end
  end

endmodule

@@ rtl/lcg_skip_ahead.sv @@
// lcg_skip_ahead: jumps a 32-bit LCG state (x*214013 + 2531011 mod 2^32)
// forward by step_count steps in one transaction.
//
// Input channel: in_valid / in_ready carry seed_in and step_count.
// Output channel: out_valid / out_ready carry next_seed.
// A step count of zero means 2^32 steps and returns seed_in unchanged.
//
// The jump runs through 32 register stages, one per bit of step_count; each
// stage holds one 32x32 multiply and add with a per-bit constant pair.
// When the output is not stalled, a transaction moves through the stage registers
// in order, and out_valid rises once it reaches the last one. One transaction
// enters per cycle while the output is not stalled, so throughput is 1 per cycle.
//
// All stages advance together. While out_valid is high and out_ready is low
// the whole pipeline holds and in_ready is low; nothing is dropped or
// repeated.
//
// Synchronous reset (rst) clears all stage valid bits; the pipeline is ready
// in the first cycle after reset.
module lcg_skip_ahead (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] seed_in,
  input  logic [31:0] step_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_seed
);

  localparam int unsigned Stages = lcgsa_pkg::StepBits;

  lcgsa_pkg::stage_t pipe [Stages+1];
  logic              en;

  assign en       = !pipe[Stages].valid || out_ready;
  assign in_ready = en;

  assign pipe[0] = {in_valid, seed_in, step_count};

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam logic [31:0] MulK = lcgsa_pkg::jump_mul(k);
    localparam logic [31:0] AddK = lcgsa_pkg::jump_add(k);

    lcgsa_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .mul_k     (MulK),
      .add_k     (AddK),
      .stage_in  (pipe[k]),
      .stage_out (pipe[k+1])
    );
  end

  assign out_valid = pipe[Stages].valid;
  assign next_seed = pipe[Stages].seed;

endmodule

@@ rtl/lcgsa_checker.sv @@
module lcgsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] seed_in,
  input logic [31:0] step_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] next_seed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_seed))
    else $error("output transaction changed while stalled");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_rise_needs_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_ready))
    else $error("output appeared while pipeline held");

endmodule

bind lcg_skip_ahead lcgsa_checker u_lcgsa_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned CalmItems = 150;
  localparam int unsigned MaxReported = 10;

  class jump_checker;
    logic [31:0] expected_seeds[$];
    int unsigned errors;
    int unsigned checked;

    function logic [31:0] advance_seed(logic [31:0] seed, logic [31:0] steps);
      logic [31:0] mul_acc;
      logic [31:0] add_acc;
      logic [31:0] mul_pow;
      logic [31:0] add_pow;
      mul_acc = 32'd1;
      add_acc = 32'd0;
      mul_pow = lcgsa_pkg::LcgMul;
      add_pow = lcgsa_pkg::LcgInc;
      for (int b = 0; b < lcgsa_pkg::StepBits; b++) begin
        if (steps[b]) begin
          mul_acc = mul_acc * mul_pow;
          add_acc = add_acc * mul_pow + add_pow;
        end
        add_pow = (mul_pow + 32'd1) * add_pow;
        mul_pow = mul_pow * mul_pow;
      end
      return seed * mul_acc + add_acc;
    endfunction

    function void note_request(logic [31:0] seed, logic [31:0] steps);
      expected_seeds = {expected_seeds, advance_seed(seed, steps)};
    endfunction

    function void check_seed(logic [31:0] got);
      logic [31:0] want;
      checked++;
      if (expected_seeds.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("unexpected next_seed %08h at %0t", got, $realtime);
      end else begin
        want = expected_seeds.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MaxReported)
            $display("next_seed mismatch: expected %08h, got %08h at %0t",
                     want, got, $realtime);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_seeds.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] seed_in;
  logic [31:0] step_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] next_seed;

  jump_checker board = new();
  bit          calm;
  bit          rx_holding;
  bit          squeeze_done;
  int unsigned idle_cycles;

  lcg_skip_ahead uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seed_in    (seed_in),
    .step_count (step_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .next_seed  (next_seed)
  );

  always #5 clk = ~clk;

  // sample between edges: inputs only move at the rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_request(seed_in, step_count);
      if (out_valid && out_ready)
        board.check_seed(next_seed);
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [31:0] seed, input logic [31:0] steps);
    in_valid   <= 1'b1;
    seed_in    <= seed;
    step_count <= steps;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_steps();
    logic [31:0] steps;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: steps = $urandom;
      4, 5:       steps = $urandom_range(1, 64);
      6:          steps = 32'd1 << $urandom_range(0, 31);
      7:          steps = 32'd0;
      8:          steps = ~(32'd1 << $urandom_range(0, 31));
      default:    steps = $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
    endcase
    return steps;
  endfunction

  function automatic logic [31:0] pick_seed();
    logic [31:0] seed;
    case ($urandom_range(0, 7))
      0:       seed = 32'd0;
      1:       seed = 32'hFFFF_FFFF;
      default: seed = $urandom;
    endcase
    return seed;
  endfunction

  // output side: random stall bursts, one long hold-off to back up the pipeline
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!squeeze_done && board.checked >= 60) begin
        squeeze_done = 1'b1;
        rx_holding   = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_holding = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    seed_in    <= 32'd0;
    step_count <= 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h1234_5678, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'hFFFF_FFFF, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0002);
    send_request(32'h0000_0001, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hA5A5_A5A5, 32'h8000_0000);
    send_request(32'h5A5A_5A5A, 32'h7FFF_FFFF);
    send_request(32'hDEAD_BEEF, 32'h5555_5555);
    send_request(32'h0000_0000, 32'hAAAA_AAAA);
    send_request(32'h8000_0000, 32'h0001_0000);
    send_request(32'h7FFF_FFFF, 32'h0000_0003);
    send_request(32'h0000_0001, 32'h0000_0100);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    pause_sender();

    for (int i = 0; i < RandomItems; i++) begin
      if (i >= RandomItems - CalmItems)
        calm = 1'b1;
      if (!calm && !rx_holding && $urandom_range(0, 5) == 0)
        pause_sender();
      send_request(pick_seed(), pick_steps());
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
